>>> design/cubic_bezier_subdivide_core_assert.svh
// Assertion macros for the cubic Bezier subdivision core.
// Included by the top level; needs nothing else.
`ifndef CUBIC_BEZIER_SUBDIVIDE_CORE_ASSERT_SVH
`define CUBIC_BEZIER_SUBDIVIDE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CBS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cubic_bezier_subdivide_core: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cubic_bezier_subdivide_core: next-cycle check failed");

`endif

>>> design/cbs_pkg.sv
// Shared types and constants of the cubic Bezier subdivision core.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package cbs_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_START_X = 3'd0,
    REG_START_Y = 3'd1,
    REG_CTRL1_X = 3'd2,
    REG_CTRL1_Y = 3'd3,
    REG_CTRL2_X = 3'd4,
    REG_CTRL2_Y = 3'd5,
    REG_END_X   = 3'd6,
    REG_END_Y   = 3'd7
  } cfg_reg_t;

  // Control point and axis positions.
  localparam int NUM_CTRL  = 4;
  localparam int NUM_AXES  = 2;
  localparam int PT_START  = 0;
  localparam int PT_CTRL1  = 1;
  localparam int PT_CTRL2  = 2;
  localparam int PT_END    = 3;
  localparam int AXIS_X    = 0;
  localparam int AXIS_Y    = 1;

  // Queue between front and engine; depth is a power of two.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = 1;

  // Engine schedule and output sequence lengths.
  localparam int STEP_BITS = 3;
  localparam logic [STEP_BITS-1:0] STEP_LAST  = 3'd7;
  localparam logic [STEP_BITS-1:0] POINT_LAST = 3'd7;

  // Destination of one interpolation in the engine.
  typedef enum logic [2:0] {
    DST_NONE,
    DST_A,
    DST_B,
    DST_C,
    DST_AB,
    DST_BC,
    DST_ABC
  } dest_t;

  // Interpolation issued at each engine step. Step five is a gap so that
  // the second-level results are written before the last level reads them.
  function automatic dest_t sched_dest(input logic [STEP_BITS-1:0] step);
    dest_t d;
    case (step)
      3'd0:    d = DST_A;
      3'd1:    d = DST_B;
      3'd2:    d = DST_C;
      3'd3:    d = DST_AB;
      3'd4:    d = DST_BC;
      3'd6:    d = DST_ABC;
      default: d = DST_NONE;
    endcase
    return d;
  endfunction

endpackage

>>> design/cbs_if.sv
// Valid/ready channel interfaces of the cubic Bezier subdivision core.
// Split-parameter items in, control-point items out; no dependencies.
`timescale 1ns / 1ps

interface cbs_in_if #(
  parameter int T_BITS = 17
);
  logic              valid;
  logic              ready;
  logic [T_BITS-1:0] t_param;

  modport source (output valid, output t_param, input ready);
  modport sink   (input valid, input t_param, output ready);
endinterface

interface cbs_out_if #(
  parameter int COORD_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic                         which_half;
  logic [1:0]                   point_index;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         last_point;

  modport source (output valid, output which_half, output point_index,
                  output point_x, output point_y, output last_point,
                  input ready);
  modport sink   (input valid, input which_half, input point_index,
                  input point_x, input point_y, input last_point,
                  output ready);
endinterface

>>> design/cubic_bezier_subdivide_core.sv
// Cubic Bezier subdivision core: splits a curve held in configuration at
// each incoming parameter t by de Casteljau's construction and sends the
// eight control points of the two halves, left half first. Each item
// yields eight result items, one a cycle while the receiver is ready; the
// eight-step interpolation schedule of the engine runs on the next item
// while the previous points are being sent. From acceptance, an item
// passes the queue, the engine steps and the handoff before its first
// point. Coordinates are signed fixed point with FRAC_BITS fraction bits;
// t above 1.0 is taken as 1.0. Write the control points only while the
// block is idle.
// Depends on cbs_pkg, cbs_if, cbs_front, cbs_engine, cbs_emit and the
// assertion macro header.
`timescale 1ns / 1ps
`include "cubic_bezier_subdivide_core_assert.svh"

module cubic_bezier_subdivide_core #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  cbs_in_if.sink                t_chan,
  cbs_out_if.source             point_chan,
  input  logic                  cfg_wr_en,
  input  cbs_pkg::cfg_reg_t     cfg_index,
  input  logic [COORD_BITS-1:0] cfg_data
);
  import cbs_pkg::*;

  logic signed [COORD_BITS-1:0] ctrl_pt [NUM_CTRL][NUM_AXES];

  logic               q_valid;
  logic [FRAC_BITS:0] q_t;
  logic               q_pop;
  logic               done;
  logic               take;

  logic signed [COORD_BITS-1:0] res_a   [NUM_AXES];
  logic signed [COORD_BITS-1:0] res_ab  [NUM_AXES];
  logic signed [COORD_BITS-1:0] res_abc [NUM_AXES];
  logic signed [COORD_BITS-1:0] res_bc  [NUM_AXES];
  logic signed [COORD_BITS-1:0] res_c   [NUM_AXES];

  // Control point registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < NUM_CTRL; p++) begin
        for (int ax = 0; ax < NUM_AXES; ax++) begin
          ctrl_pt[p][ax] <= '0;
        end
      end
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_START_X: ctrl_pt[PT_START][AXIS_X] <= cfg_data;
        REG_START_Y: ctrl_pt[PT_START][AXIS_Y] <= cfg_data;
        REG_CTRL1_X: ctrl_pt[PT_CTRL1][AXIS_X] <= cfg_data;
        REG_CTRL1_Y: ctrl_pt[PT_CTRL1][AXIS_Y] <= cfg_data;
        REG_CTRL2_X: ctrl_pt[PT_CTRL2][AXIS_X] <= cfg_data;
        REG_CTRL2_Y: ctrl_pt[PT_CTRL2][AXIS_Y] <= cfg_data;
        REG_END_X:   ctrl_pt[PT_END][AXIS_X]   <= cfg_data;
        REG_END_Y:   ctrl_pt[PT_END][AXIS_Y]   <= cfg_data;
        default:     ;
      endcase
    end
  end

  cbs_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .t_chan  (t_chan),
    .q_valid (q_valid),
    .q_t     (q_t),
    .q_pop   (q_pop)
  );

  cbs_engine #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_t     (q_t),
    .q_pop   (q_pop),
    .ctrl_pt (ctrl_pt),
    .done    (done),
    .take    (take),
    .res_a   (res_a),
    .res_ab  (res_ab),
    .res_abc (res_abc),
    .res_bc  (res_bc),
    .res_c   (res_c)
  );

  cbs_emit #(
    .COORD_BITS (COORD_BITS)
  ) u_emit (
    .clk        (clk),
    .rst        (rst),
    .done       (done),
    .take       (take),
    .p_start    (ctrl_pt[PT_START]),
    .p_end      (ctrl_pt[PT_END]),
    .res_a      (res_a),
    .res_ab     (res_ab),
    .res_abc    (res_abc),
    .res_bc     (res_bc),
    .res_c      (res_c),
    .point_chan (point_chan)
  );

  // Results are handed over only once the engine has finished them.
  `CBS_ASSERT_NOW(a_take_needs_done, clk, rst, take, done)
  // A handoff always opens with the start point of the left half.
  `CBS_ASSERT_NEXT(a_take_starts_left, clk, rst, take, point_chan.valid && !point_chan.which_half && point_chan.point_index == 2'd0)
  // A freshly started item cannot already be finished in the next cycle.
  `CBS_ASSERT_NEXT(a_start_not_done, clk, rst, q_pop, !done)

endmodule

>>> design/cbs_front.sv
// Front end: accepts split-parameter items, clamps them to 1.0 and queues them.
// Depends on cbs_pkg and cbs_in_if.
`timescale 1ns / 1ps

module cbs_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  cbs_in_if.sink             t_chan,
  output logic               q_valid,
  output logic [FRAC_BITS:0] q_t,
  input  logic               q_pop
);
  import cbs_pkg::*;

  localparam logic [FRAC_BITS:0] T_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [FRAC_BITS:0]   q_mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;
  logic                 push;
  logic [FRAC_BITS:0]   t_clamped;

  // Room in the queue is all that gates acceptance.
  assign t_chan.ready = (count != (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign push         = t_chan.valid && t_chan.ready;
  assign q_valid      = (count != '0);
  assign q_t          = q_mem[rd_ptr];

  // Anything above one is taken as exactly one.
  assign t_clamped = (t_chan.t_param > T_ONE) ? T_ONE : t_chan.t_param;

  // Queue storage; no reset needed for the payload.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= t_clamped;
    end
  end

  // Pointers wrap naturally since the depth is a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> design/cbs_engine.sv
// Interpolation engine: runs the six de Casteljau interpolations per axis
// over an eight-step schedule on a two-stage difference/multiply pipeline.
// Depends on cbs_pkg.
`timescale 1ns / 1ps

module cbs_engine #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  logic [FRAC_BITS:0]           q_t,
  output logic                         q_pop,
  input  logic signed [COORD_BITS-1:0] ctrl_pt [cbs_pkg::NUM_CTRL][cbs_pkg::NUM_AXES],
  output logic                         done,
  input  logic                         take,
  output logic signed [COORD_BITS-1:0] res_a   [cbs_pkg::NUM_AXES],
  output logic signed [COORD_BITS-1:0] res_ab  [cbs_pkg::NUM_AXES],
  output logic signed [COORD_BITS-1:0] res_abc [cbs_pkg::NUM_AXES],
  output logic signed [COORD_BITS-1:0] res_bc  [cbs_pkg::NUM_AXES],
  output logic signed [COORD_BITS-1:0] res_c   [cbs_pkg::NUM_AXES]
);
  import cbs_pkg::*;

  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int HI_BITS   = COORD_BITS + 1 - FRAC_BITS;
  localparam int SUM_BITS  = COORD_BITS + 3;
  localparam int LO_BITS   = 2 * FRAC_BITS + 1;

  logic                 busy;
  logic [STEP_BITS-1:0] step;
  logic                 start;
  dest_t                op_dest;
  logic [FRAC_BITS:0]   t_reg;
  logic signed [FRAC_BITS+1:0] t_s;

  logic signed [COORD_BITS-1:0] op_a [NUM_AXES];
  logic signed [COORD_BITS-1:0] op_b [NUM_AXES];

  // Difference stage registers.
  dest_t                        dv_dest;
  logic signed [COORD_BITS-1:0] dv_a [NUM_AXES];
  logic signed [DIFF_BITS-1:0]  dv_d [NUM_AXES];

  // Multiply stage signals.
  logic signed [HI_BITS-1:0]    hi   [NUM_AXES];
  logic [FRAC_BITS-1:0]         lo   [NUM_AXES];
  logic signed [SUM_BITS-1:0]   hi_t [NUM_AXES];
  logic [LO_BITS-1:0]           lo_t [NUM_AXES];
  logic signed [SUM_BITS-1:0]   sum  [NUM_AXES];
  logic signed [COORD_BITS-1:0] lerp [NUM_AXES];

  logic signed [COORD_BITS-1:0] res_b [NUM_AXES];

  // A new item starts once the previous results are gone or leaving now.
  assign start = q_valid && !busy && (!done || take);
  assign q_pop = start;

  always_comb begin
    if (start) begin
      op_dest = DST_A;
    end else if (busy) begin
      op_dest = sched_dest(step);
    end else begin
      op_dest = DST_NONE;
    end
  end

  // Operand selection for the interpolation issued this cycle.
  always_comb begin
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      case (op_dest)
        DST_A: begin
          op_a[ax] = ctrl_pt[PT_START][ax];
          op_b[ax] = ctrl_pt[PT_CTRL1][ax];
        end
        DST_B: begin
          op_a[ax] = ctrl_pt[PT_CTRL1][ax];
          op_b[ax] = ctrl_pt[PT_CTRL2][ax];
        end
        DST_C: begin
          op_a[ax] = ctrl_pt[PT_CTRL2][ax];
          op_b[ax] = ctrl_pt[PT_END][ax];
        end
        DST_AB: begin
          op_a[ax] = res_a[ax];
          op_b[ax] = res_b[ax];
        end
        DST_BC: begin
          op_a[ax] = res_b[ax];
          op_b[ax] = res_c[ax];
        end
        DST_ABC: begin
          op_a[ax] = res_ab[ax];
          op_b[ax] = res_bc[ax];
        end
        default: begin
          op_a[ax] = '0;
          op_b[ax] = '0;
        end
      endcase
    end
  end

  // The difference splits into a whole part times t and a fraction part
  // times t shifted down, which together give the floor exactly.
  assign t_s = $signed({1'b0, t_reg});

  always_comb begin
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      hi[ax]   = dv_d[ax][DIFF_BITS-1:FRAC_BITS];
      lo[ax]   = dv_d[ax][FRAC_BITS-1:0];
      hi_t[ax] = hi[ax] * t_s;
      lo_t[ax] = lo[ax] * t_reg;
      sum[ax]  = SUM_BITS'(dv_a[ax]) + hi_t[ax]
               + $signed(SUM_BITS'(lo_t[ax][LO_BITS-1:FRAC_BITS]));
      lerp[ax] = sum[ax][COORD_BITS-1:0];
    end
  end

  // Sequencing: step counter, handoff flag and pipeline tag.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      step    <= '0;
      done    <= 1'b0;
      dv_dest <= DST_NONE;
    end else begin
      dv_dest <= op_dest;
      if (take) begin
        done <= 1'b0;
      end
      if (start) begin
        busy <= 1'b1;
        step <= STEP_BITS'(1);
      end else if (busy) begin
        if (step == STEP_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      t_reg <= q_t;
    end
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      if (op_dest != DST_NONE) begin
        dv_a[ax] <= op_a[ax];
        dv_d[ax] <= {op_b[ax][COORD_BITS-1], op_b[ax]} - {op_a[ax][COORD_BITS-1], op_a[ax]};
      end
      case (dv_dest)
        DST_A:   res_a[ax]   <= lerp[ax];
        DST_B:   res_b[ax]   <= lerp[ax];
        DST_C:   res_c[ax]   <= lerp[ax];
        DST_AB:  res_ab[ax]  <= lerp[ax];
        DST_BC:  res_bc[ax]  <= lerp[ax];
        DST_ABC: res_abc[ax] <= lerp[ax];
        default: ;
      endcase
    end
  end

endmodule

>>> design/cbs_emit.sv
// Back end: holds one finished split and sends its eight control points.
// Depends on cbs_pkg and cbs_out_if.
`timescale 1ns / 1ps

module cbs_emit #(
  parameter int COORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         done,
  output logic                         take,
  input  logic signed [COORD_BITS-1:0] p_start [cbs_pkg::NUM_AXES],
  input  logic signed [COORD_BITS-1:0] p_end   [cbs_pkg::NUM_AXES],
  input  logic signed [COORD_BITS-1:0] res_a   [cbs_pkg::NUM_AXES],
  input  logic signed [COORD_BITS-1:0] res_ab  [cbs_pkg::NUM_AXES],
  input  logic signed [COORD_BITS-1:0] res_abc [cbs_pkg::NUM_AXES],
  input  logic signed [COORD_BITS-1:0] res_bc  [cbs_pkg::NUM_AXES],
  input  logic signed [COORD_BITS-1:0] res_c   [cbs_pkg::NUM_AXES],
  cbs_out_if.source                    point_chan
);
  import cbs_pkg::*;

  logic                 full;
  logic [STEP_BITS-1:0] idx;
  logic                 sent;
  logic                 last_sent;

  logic signed [COORD_BITS-1:0] h_a   [NUM_AXES];
  logic signed [COORD_BITS-1:0] h_ab  [NUM_AXES];
  logic signed [COORD_BITS-1:0] h_abc [NUM_AXES];
  logic signed [COORD_BITS-1:0] h_bc  [NUM_AXES];
  logic signed [COORD_BITS-1:0] h_c   [NUM_AXES];
  logic signed [COORD_BITS-1:0] pt    [NUM_AXES];

  assign sent      = full && point_chan.ready;
  assign last_sent = sent && (idx == POINT_LAST);
  // New results load as soon as the hold is empty or its last item leaves.
  assign take      = done && (!full || last_sent);

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      idx  <= '0;
    end else if (take) begin
      full <= 1'b1;
      idx  <= '0;
    end else if (last_sent) begin
      full <= 1'b0;
      idx  <= '0;
    end else if (sent) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      h_a   <= res_a;
      h_ab  <= res_ab;
      h_abc <= res_abc;
      h_bc  <= res_bc;
      h_c   <= res_c;
    end
  end

  // Left half P0, A, AB, ABC, then right half ABC, BC, C, P3.
  always_comb begin
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      case (idx)
        3'd0:       pt[ax] = p_start[ax];
        3'd1:       pt[ax] = h_a[ax];
        3'd2:       pt[ax] = h_ab[ax];
        3'd3, 3'd4: pt[ax] = h_abc[ax];
        3'd5:       pt[ax] = h_bc[ax];
        3'd6:       pt[ax] = h_c[ax];
        default:    pt[ax] = p_end[ax];
      endcase
    end
  end

  assign point_chan.valid       = full;
  assign point_chan.which_half  = idx[2];
  assign point_chan.point_index = idx[1:0];
  assign point_chan.point_x     = pt[AXIS_X];
  assign point_chan.point_y     = pt[AXIS_Y];
  assign point_chan.last_point  = (idx == POINT_LAST);

endmodule
